@@ src/dbpm_pkg.sv @@
// ----------------------------------------------------------------------------
// dbpm_pkg
// Shared types and constants of the dot-bracket pair matcher.
// ----------------------------------------------------------------------------
package dbpm_pkg;

  localparam int unsigned MaxLen     = 1024;
  localparam int unsigned StackDepth = 512;
  localparam int unsigned ResDepth   = 4;

  localparam int unsigned PosW      = 10;
  localparam int unsigned PosCntW   = $clog2(MaxLen + 1);
  localparam int unsigned StackAw   = $clog2(StackDepth);
  localparam int unsigned CntW      = $clog2(StackDepth + 1);
  localparam int unsigned ResAw     = $clog2(ResDepth);
  localparam int unsigned ResCntW   = $clog2(ResDepth + 1);
  localparam int unsigned MinLoopW  = 10;
  localparam int unsigned MaskW     = 16;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [MaskW-1:0]    PairMaskReset = 16'h5A48;
  localparam logic [MinLoopW-1:0] MinLoopReset  = 10'd3;

  typedef enum logic [1:0] {
    SymOpen  = 2'd0,
    SymClose = 2'd1,
    SymDot   = 2'd2
  } sym_e;

  typedef enum logic {
    KindPair    = 1'b0,
    KindVerdict = 1'b1
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPairMask = 1'b0,
    CfgMinLoop  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [PosW-1:0] pos;
    logic [1:0]      base;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    kind_e           kind;
    logic [PosW-1:0] open_pos;
    logic [PosW-1:0] close_pos;
    logic            pair_allowed;
    logic            loop_ok;
    logic            structure_valid;
    logic            pairs_valid;
    logic            loops_valid;
    logic            end_of_run;
  } res_t;

endpackage

@@ src/dbpm_if.sv @@
// ----------------------------------------------------------------------------
// dbpm_if
// Valid/ready channels of the dot-bracket pair matcher.
// ----------------------------------------------------------------------------
interface dbpm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] symbol;
  logic [1:0] base;
  logic       last;

  modport source (output valid, symbol, base, last, input ready);
  modport sink   (input valid, symbol, base, last, output ready);
endinterface

interface dbpm_out_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [dbpm_pkg::PosW-1:0] open_pos;
  logic [dbpm_pkg::PosW-1:0] close_pos;
  logic                      pair_allowed;
  logic                      loop_ok;
  logic                      structure_valid;
  logic                      pairs_valid;
  logic                      loops_valid;
  logic                      end_of_run;

  modport source (output valid, kind, open_pos, close_pos, pair_allowed, loop_ok,
                  structure_valid, pairs_valid, loops_valid, end_of_run,
                  input ready);
  modport sink   (input valid, kind, open_pos, close_pos, pair_allowed, loop_ok,
                  structure_valid, pairs_valid, loops_valid, end_of_run,
                  output ready);
endinterface

@@ src/dot_bracket_pair_matcher.sv @@
// ----------------------------------------------------------------------------
// dot_bracket_pair_matcher
// Streams one structure position per transaction and reports bracket pairs
// and a per-structure verdict. The block takes one transaction per cycle;
// each one is resolved in the cycle it is accepted. Open brackets are held
// in a 512 x 12 RAM with the top entry cached in flops and the entry below
// it prefetched through the RAM's registered read port, so pushes and pops
// can follow each other in consecutive cycles. Results leave through a
// four-entry queue; a last position that closes a pair yields two results,
// and input ready drops while fewer than two queue slots are free. With the
// output side always ready the sustained rate is one transaction per cycle.
// ----------------------------------------------------------------------------
module dot_bracket_pair_matcher (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dbpm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dbpm_pkg::CfgDataW-1:0] cfg_wdata_i,
  dbpm_in_if.sink                       in_i,
  dbpm_out_if.source                    out_o
);

  logic [dbpm_pkg::MaskW-1:0]    pair_mask_q;
  logic [dbpm_pkg::MinLoopW-1:0] min_loop_q;

  logic [dbpm_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [dbpm_pkg::PosCntW-1:0] pos_q, pos_d;
  logic                         unb_q, unb_d;
  logic                         bad_q, bad_d;
  logic                         short_q, short_d;
  dbpm_pkg::entry_t             top_q, top_d;
  logic                         byp_q, byp_d;
  dbpm_pkg::entry_t             byp_data_q;

  logic                            acc;
  logic                            push;
  logic                            pop;
  logic                            mem_we;
  logic [dbpm_pkg::StackAw-1:0]    waddr;
  logic [dbpm_pkg::StackAw-1:0]    raddr;
  logic [dbpm_pkg::CntW-1:0]       cnt_m1;
  logic [dbpm_pkg::CntW-1:0]       cnt_m2;
  logic [dbpm_pkg::EntryW-1:0]     rdata;
  dbpm_pkg::entry_t                below;
  logic [dbpm_pkg::PosW-1:0]       cur_pos;
  logic [dbpm_pkg::PosW-1:0]       pair_dist;
  logic                            allowed;
  logic                            loop_ok;
  logic                            sv;

  dbpm_pkg::res_t                  pair_res;
  dbpm_pkg::res_t                  verdict_res;
  logic                            wr_a;
  logic                            wr_b;
  dbpm_pkg::res_t                  res_a;

  dbpm_pkg::res_t                  fifo_q [dbpm_pkg::ResDepth];
  logic [dbpm_pkg::ResAw-1:0]      wr_ptr_q, rd_ptr_q;
  logic [dbpm_pkg::ResCntW-1:0]    fifo_cnt_q;
  logic                            out_pop;
  dbpm_pkg::res_t                  head;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_mask_q <= dbpm_pkg::PairMaskReset;
      min_loop_q  <= dbpm_pkg::MinLoopReset;
    end else if (cfg_we_i) begin
      case (dbpm_pkg::cfg_idx_e'(cfg_idx_i))
        dbpm_pkg::CfgPairMask: pair_mask_q <= cfg_wdata_i[dbpm_pkg::MaskW-1:0];
        dbpm_pkg::CfgMinLoop:  min_loop_q  <= cfg_wdata_i[dbpm_pkg::MinLoopW-1:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = fifo_cnt_q <= dbpm_pkg::ResCntW'(dbpm_pkg::ResDepth - 2);
  assign acc        = in_i.valid && in_i.ready;

  assign cur_pos   = pos_q[dbpm_pkg::PosW-1:0];
  assign below     = byp_q ? byp_data_q : dbpm_pkg::entry_t'(rdata);
  assign cnt_m1    = cnt_q - dbpm_pkg::CntW'(1);
  assign pair_dist = cur_pos - top_q.pos;
  assign allowed   = pair_mask_q[{top_q.base, in_i.base}];
  assign loop_ok   = pair_dist > min_loop_q;

  always_comb begin
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    unb_d   = unb_q;
    bad_d   = bad_q;
    short_d = short_q;
    top_d   = top_q;
    push    = 1'b0;
    pop     = 1'b0;
    sv      = 1'b0;

    if (acc) begin
      if (pos_q >= dbpm_pkg::PosCntW'(dbpm_pkg::MaxLen)) begin
        unb_d = 1'b1;
      end else begin
        pos_d = pos_q + dbpm_pkg::PosCntW'(1);
        case (dbpm_pkg::sym_e'(in_i.symbol))
          dbpm_pkg::SymOpen: begin
            if (cnt_q == dbpm_pkg::CntW'(dbpm_pkg::StackDepth)) begin
              unb_d = 1'b1;
            end else begin
              push       = 1'b1;
              cnt_d      = cnt_q + dbpm_pkg::CntW'(1);
              top_d.pos  = cur_pos;
              top_d.base = in_i.base;
            end
          end
          dbpm_pkg::SymClose: begin
            if (cnt_q == '0) begin
              unb_d = 1'b1;
            end else begin
              pop   = 1'b1;
              cnt_d = cnt_m1;
              top_d = below;
              if (!allowed) begin
                bad_d = 1'b1;
              end
              if (!loop_ok) begin
                short_d = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end

      sv = !unb_d && (cnt_d == '0);
      if (in_i.last) begin
        cnt_d   = '0;
        pos_d   = '0;
        unb_d   = 1'b0;
        bad_d   = 1'b0;
        short_d = 1'b0;
      end
    end
  end

  // Spill the old top into the RAM on push; prefetch the entry below the new top
  assign mem_we = push && (cnt_q != '0);
  assign waddr  = cnt_m1[dbpm_pkg::StackAw-1:0];
  assign cnt_m2 = cnt_d - dbpm_pkg::CntW'(2);
  assign raddr  = cnt_m2[dbpm_pkg::StackAw-1:0];
  assign byp_d  = mem_we;

  dbpm_ram #(
    .Width (dbpm_pkg::EntryW),
    .Depth (dbpm_pkg::StackDepth)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (top_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      pos_q   <= '0;
      unb_q   <= 1'b0;
      bad_q   <= 1'b0;
      short_q <= 1'b0;
      byp_q   <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      unb_q   <= unb_d;
      bad_q   <= bad_d;
      short_q <= short_d;
      byp_q   <= byp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q      <= top_d;
    byp_data_q <= top_q;
  end

  // Result formation
  always_comb begin
    pair_res                 = '0;
    pair_res.kind            = dbpm_pkg::KindPair;
    pair_res.open_pos        = top_q.pos;
    pair_res.close_pos       = cur_pos;
    pair_res.pair_allowed    = allowed;
    pair_res.loop_ok         = loop_ok;
    pair_res.end_of_run      = !in_i.last;

    verdict_res                 = '0;
    verdict_res.kind            = dbpm_pkg::KindVerdict;
    verdict_res.structure_valid = sv;
    verdict_res.pairs_valid     = !(bad_q || (pop && !allowed));
    verdict_res.loops_valid     = !(short_q || (pop && !loop_ok));
    verdict_res.end_of_run      = 1'b1;
  end

  assign wr_a  = pop || (acc && in_i.last);
  assign wr_b  = pop && in_i.last;
  assign res_a = pop ? pair_res : verdict_res;

  // Result queue
  assign out_pop = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      wr_ptr_q   <= wr_ptr_q + dbpm_pkg::ResAw'(wr_a) + dbpm_pkg::ResAw'(wr_b);
      rd_ptr_q   <= rd_ptr_q + dbpm_pkg::ResAw'(out_pop);
      fifo_cnt_q <= fifo_cnt_q + dbpm_pkg::ResCntW'(wr_a) + dbpm_pkg::ResCntW'(wr_b)
                    - dbpm_pkg::ResCntW'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      fifo_q[wr_ptr_q] <= res_a;
    end
    if (wr_b) begin
      fifo_q[wr_ptr_q + dbpm_pkg::ResAw'(1)] <= verdict_res;
    end
  end

  assign head                  = fifo_q[rd_ptr_q];
  assign out_o.valid           = fifo_cnt_q != '0;
  assign out_o.kind            = head.kind;
  assign out_o.open_pos        = head.open_pos;
  assign out_o.close_pos       = head.close_pos;
  assign out_o.pair_allowed    = head.pair_allowed;
  assign out_o.loop_ok         = head.loop_ok;
  assign out_o.structure_valid = head.structure_valid;
  assign out_o.pairs_valid     = head.pairs_valid;
  assign out_o.loops_valid     = head.loops_valid;
  assign out_o.end_of_run      = head.end_of_run;

endmodule

@@ src/dbpm_ram.sv @@
// ----------------------------------------------------------------------------
// dbpm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dbpm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/dbpm_checker.sv @@
// ----------------------------------------------------------------------------
// dbpm_checker
// Port-level checks of the dot-bracket pair matcher, bound to the top level.
// ----------------------------------------------------------------------------
module dbpm_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic                      out_kind_i,
  input logic [dbpm_pkg::PosW-1:0] out_open_pos_i,
  input logic [dbpm_pkg::PosW-1:0] out_close_pos_i,
  input logic                      out_end_of_run_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_open_pos_i) && $stable(out_close_pos_i)
      && $stable(out_kind_i) && $stable(out_end_of_run_i))
    else $error("result payload changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i && !(in_valid_i && in_ready_i) |=> !out_valid_i)
    else $error("result without an input transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with an empty result queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == dbpm_pkg::KindPair) |-> out_close_pos_i > out_open_pos_i)
    else $error("pair closes before it opens");

endmodule

bind dot_bracket_pair_matcher dbpm_checker u_dbpm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_kind_i       (out_o.kind),
  .out_open_pos_i   (out_o.open_pos),
  .out_close_pos_i  (out_o.close_pos),
  .out_end_of_run_i (out_o.end_of_run)
);

@@ dv/dot_bracket_pair_matcher_tb.sv @@
// ----------------------------------------------------------------------------
// dot_bracket_pair_matcher_tb
// Drives structure positions through the input channel with random gaps and
// random output stalls. A built-in pair tracker predicts every pair and
// verdict report, and each received report is checked field by field in
// order. Covers directed shapes, stack overflow, register extremes and
// random structures, mostly well formed.
// ----------------------------------------------------------------------------
module dot_bracket_pair_matcher_tb;

  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 8;
  localparam int DrainCycles   = 20;
  localparam int RandomItems   = 40;

  localparam logic [1:0] SymSpare = 2'd3;
  localparam logic [1:0] BaseA    = 2'd0;
  localparam logic [1:0] BaseC    = 2'd1;
  localparam logic [1:0] BaseG    = 2'd2;
  localparam logic [1:0] BaseU    = 2'd3;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  dbpm_pkg::cfg_idx_e            cfg_idx;
  logic [dbpm_pkg::CfgDataW-1:0] cfg_wdata;

  dbpm_in_if  in_if ();
  dbpm_out_if out_if ();

  dot_bracket_pair_matcher DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // pair tracker state
  logic [dbpm_pkg::MaskW-1:0]    mask_reg;
  logic [dbpm_pkg::MinLoopW-1:0] min_loop_reg;
  dbpm_pkg::entry_t              model_stack [dbpm_pkg::StackDepth];
  logic [dbpm_pkg::CntW-1:0]     stack_fill;
  logic [dbpm_pkg::PosCntW-1:0]  pos_count;
  logic                          lost_balance;
  logic                          bad_pair_seen;
  logic                          short_loop_seen;

  dbpm_pkg::res_t predicted_reports [$];

  int  mismatches   = 0;
  int  items_sent   = 0;
  int  quiet_cycles = 0;
  bit  no_idle      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_structure_state();
    stack_fill      = '0;
    pos_count       = '0;
    lost_balance    = 1'b0;
    bad_pair_seen   = 1'b0;
    short_loop_seen = 1'b0;
  endfunction

  function automatic void track_position(logic [1:0] sym, logic [1:0] nt, logic last);
    dbpm_pkg::res_t            rep;
    dbpm_pkg::entry_t          top;
    logic [dbpm_pkg::PosW-1:0] here;
    logic [dbpm_pkg::PosW:0]   pair_dist;
    logic [3:0]                combo;
    if (pos_count >= dbpm_pkg::MaxLen) begin
      lost_balance = 1'b1;
    end else begin
      here      = pos_count[dbpm_pkg::PosW-1:0];
      pos_count = pos_count + 1'b1;
      if (sym == dbpm_pkg::SymOpen) begin
        if (stack_fill >= dbpm_pkg::StackDepth) begin
          lost_balance = 1'b1;
        end else begin
          model_stack[stack_fill[dbpm_pkg::StackAw-1:0]] = '{pos: here, base: nt};
          stack_fill = stack_fill + 1'b1;
        end
      end else if (sym == dbpm_pkg::SymClose) begin
        if (stack_fill == 0) begin
          lost_balance = 1'b1;
        end else begin
          stack_fill = stack_fill - 1'b1;
          top       = model_stack[stack_fill[dbpm_pkg::StackAw-1:0]];
          combo     = {top.base, nt};
          pair_dist = {1'b0, here} - {1'b0, top.pos};
          rep              = '0;
          rep.kind         = dbpm_pkg::KindPair;
          rep.open_pos     = top.pos;
          rep.close_pos    = here;
          rep.pair_allowed = mask_reg[combo];
          rep.loop_ok      = pair_dist > min_loop_reg;
          rep.end_of_run   = !last;
          if (!rep.pair_allowed) bad_pair_seen = 1'b1;
          if (!rep.loop_ok) short_loop_seen = 1'b1;
          predicted_reports.push_back(rep);
        end
      end
    end
    if (last) begin
      rep                 = '0;
      rep.kind            = dbpm_pkg::KindVerdict;
      rep.structure_valid = !lost_balance && (stack_fill == 0);
      rep.pairs_valid     = !bad_pair_seen;
      rep.loops_valid     = !short_loop_seen;
      rep.end_of_run      = 1'b1;
      predicted_reports.push_back(rep);
      clear_structure_state();
    end
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 50) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic send_position(logic [1:0] sym, logic [1:0] nt, logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.symbol <= sym;
    in_if.base   <= nt;
    in_if.last   <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    track_position(sym, nt, last);
    items_sent++;
  endtask

  task automatic send_pattern(string shape, string bases);
    logic [1:0] sym;
    logic [1:0] nt;
    for (int i = 0; i < shape.len(); i++) begin
      case (shape[i])
        "(": sym = dbpm_pkg::SymOpen;
        ")": sym = dbpm_pkg::SymClose;
        ":": sym = SymSpare;
        default: sym = dbpm_pkg::SymDot;
      endcase
      case (bases[i])
        "A": nt = BaseA;
        "C": nt = BaseC;
        "G": nt = BaseG;
        default: nt = BaseU;
      endcase
      send_position(sym, nt, i == shape.len() - 1);
    end
  endtask

  task automatic send_structure(int len, bit well_formed);
    int         depth;
    logic [1:0] sym;
    depth = 0;
    for (int i = 0; i < len; i++) begin
      if (!well_formed) begin
        sym = 2'($urandom_range(0, 3));
      end else if (depth >= len - i) begin
        sym = dbpm_pkg::SymClose;
      end else begin
        case ($urandom_range(0, 2))
          0: sym = (depth + 1 <= len - i - 1) ? dbpm_pkg::SymOpen : dbpm_pkg::SymDot;
          1: sym = (depth > 0) ? dbpm_pkg::SymClose : dbpm_pkg::SymDot;
          default: sym = ($urandom_range(0, 3) == 0) ? SymSpare : dbpm_pkg::SymDot;
        endcase
      end
      if (sym == dbpm_pkg::SymOpen) depth++;
      else if (sym == dbpm_pkg::SymClose && depth > 0) depth--;
      send_position(sym, 2'($urandom_range(0, 3)), i == len - 1);
    end
  endtask

  task automatic set_registers(logic [15:0] mask, logic [15:0] loop);
    in_if.valid <= 1'b0;
    wait (predicted_reports.size() == 0);
    repeat (SettleCycles) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= dbpm_pkg::CfgPairMask;
    cfg_wdata <= mask;
    @(posedge clk);
    mask_reg  = mask;
    cfg_idx   <= dbpm_pkg::CfgMinLoop;
    cfg_wdata <= loop;
    @(posedge clk);
    min_loop_reg = loop[dbpm_pkg::MinLoopW-1:0];
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_register(logic [15:0] reset_val, logic [15:0] top);
    case ($urandom_range(0, 3))
      0: return reset_val;
      1: return '0;
      2: return top;
      default: return 16'($urandom_range(0, top));
    endcase
  endfunction

  task automatic test_directed_shapes();
    send_pattern("((.:))", "AGCAUU");
    send_pattern(")(...)", "UCAAAG");
    send_pattern("(()", "GAU");
    send_pattern("(", "U");
    send_pattern(".", "A");
    send_pattern("(..)", "AAAC");
  endtask

  task automatic test_stack_overflow();
    for (int i = 0; i <= dbpm_pkg::StackDepth; i++) begin
      send_position(dbpm_pkg::SymOpen, 2'($urandom_range(0, 3)), 1'b0);
    end
    send_position(dbpm_pkg::SymClose, 2'($urandom_range(0, 3)), 1'b1);
  endtask

  task automatic test_register_extremes();
    for (int k = 0; k < 4; k++) begin
      case (k)
        0: set_registers(16'h0000, 16'd0);
        1: set_registers(16'hFFFF, 16'd1023);
        2: set_registers(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 1023)));
        default: set_registers(dbpm_pkg::PairMaskReset, 16'(dbpm_pkg::MinLoopReset));
      endcase
      repeat (2) send_structure($urandom_range(2, 20), 1'b1);
    end
  endtask

  task automatic test_random_structures();
    int start;
    int len;
    start = items_sent;
    while (items_sent - start < RandomItems) begin
      no_idle = ($urandom_range(0, 5) == 0);
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
      send_structure(len, $urandom_range(0, 4) != 0);
      if ($urandom_range(0, 9) == 0) begin
        set_registers(pick_register(dbpm_pkg::PairMaskReset, 16'hFFFF),
                      pick_register(16'(dbpm_pkg::MinLoopReset), 16'd1023));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    int stall;
    out_if.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!(out_if.valid && out_if.ready)) @(posedge clk);
    end
  end

  initial begin
    dbpm_pkg::res_t got;
    dbpm_pkg::res_t want;
    bit             fire;
    forever begin
      @(posedge clk);
      fire                = rst_n && out_if.valid && out_if.ready;
      got.kind            = dbpm_pkg::kind_e'(out_if.kind);
      got.open_pos        = out_if.open_pos;
      got.close_pos       = out_if.close_pos;
      got.pair_allowed    = out_if.pair_allowed;
      got.loop_ok         = out_if.loop_ok;
      got.structure_valid = out_if.structure_valid;
      got.pairs_valid     = out_if.pairs_valid;
      got.loops_valid     = out_if.loops_valid;
      got.end_of_run      = out_if.end_of_run;
      @(negedge clk);
      if (fire) begin
        if (predicted_reports.size() == 0) begin
          report_mismatch("report received with none pending");
        end else begin
          want = predicted_reports.pop_front();
          check_field("kind", got.kind, want.kind);
          check_field("open_pos", got.open_pos, want.open_pos);
          check_field("close_pos", got.close_pos, want.close_pos);
          check_field("pair_allowed", got.pair_allowed, want.pair_allowed);
          check_field("loop_ok", got.loop_ok, want.loop_ok);
          check_field("structure_valid", got.structure_valid, want.structure_valid);
          check_field("pairs_valid", got.pairs_valid, want.pairs_valid);
          check_field("loops_valid", got.loops_valid, want.loops_valid);
          check_field("end_of_run", got.end_of_run, want.end_of_run);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no transaction for %0d cycles", WatchdogLimit);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= dbpm_pkg::CfgPairMask;
    cfg_wdata    <= '0;
    in_if.valid  <= 1'b0;
    in_if.symbol <= dbpm_pkg::SymDot;
    in_if.base   <= BaseA;
    in_if.last   <= 1'b0;
    mask_reg     = dbpm_pkg::PairMaskReset;
    min_loop_reg = dbpm_pkg::MinLoopReset;
    clear_structure_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_shapes();
    test_stack_overflow();
    test_register_extremes();
    test_random_structures();

    in_if.valid <= 1'b0;
    wait (predicted_reports.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
